// ----- hdl/ast_pkg.sv -----
// Shared constants, types and codes for the allocation site tracker.
package ast_pkg;
    localparam int TABLE_BITS = 12;
    localparam int SITE_COUNT = 19;
    localparam int SLOT_N     = 1 << TABLE_BITS;
    localparam int SITE_W     = 5;
    localparam int KEY_W      = 64;
    localparam int CNT_W      = 63;
    localparam int OCC_W      = TABLE_BITS + 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;

    localparam logic [63:0] MIX_MUL = 64'hff51afd7ed558ccd;
    localparam logic [SITE_W-1:0] UNKNOWN_SITE = SITE_W'(SITE_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] ACT_TAG   = 2'd0;
    localparam logic [1:0] ACT_UNTAG = 2'd1;

    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
    localparam logic [2:0] ST_DROPPED     = 3'd2;
    localparam logic [2:0] ST_REMOVED     = 3'd3;
    localparam logic [2:0] ST_MISS        = 3'd4;
    localparam logic [2:0] ST_DISABLED    = 3'd5;
    localparam logic [2:0] ST_READ        = 3'd6;

    localparam logic CFG_STATS_ENABLED = 1'b0;
    localparam logic CFG_TABLE_PRESENT = 1'b1;

    typedef struct packed {
        logic [1:0]            action;
        logic [KEY_W-1:0]      key;
        logic [SITE_W-1:0]     site;
        logic [CNT_W-1:0]      bytes;
        logic [TABLE_BITS-1:0] home;
    } t_req;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SITE_W-1:0] site;
    } t_slot;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction
endpackage

// ----- hdl/ast_hash.sv -----
// Multi-cycle key mixer giving a home slot with one shared 32x32 multiplier.
module ast_hash (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [63:0]                    i_key,
    output logic                           o_done,
    output logic [ast_pkg::TABLE_BITS-1:0] o_slot
);
    import ast_pkg::*;

    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_run;
    logic        r_done;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [63:0] mixed;

    assign op_a  = (r_step == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign op_b  = (r_step == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
    assign prod  = op_a * op_b;
    assign mixed = r_acc ^ (r_acc >> 33);
    assign o_slot = mixed[TABLE_BITS-1:0];
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_key ^ (i_key >> 33);
                r_step <= 2'd0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                // low product, then the two cross terms into the upper half
                if (r_step == 2'd0) begin
                    r_acc <= prod;
                end else begin
                    r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                end
                if (r_step == 2'd2) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 2'd1;
            end
        end
    end
endmodule

// ----- hdl/ast_queue.sv -----
// Two-entry request queue between the front and the table engine.
module ast_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ast_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output ast_pkg::t_req o_head
);
    import ast_pkg::*;

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ----- hdl/ast_front.sv -----
// Request front: latches a request, clamps the site, picks the byte count, hashes the key.
module ast_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [1:0]                 i_action,
    input  logic [63:0]                i_key,
    input  logic [ast_pkg::SITE_W-1:0] i_site,
    input  logic [ast_pkg::CNT_W-1:0]  i_byte_count,
    input  logic [ast_pkg::CNT_W-1:0]  i_fallback_bytes,
    output logic                       o_busy,
    output logic                       o_push,
    output ast_pkg::t_req              o_req
);
    import ast_pkg::*;

    logic                  r_hashing;
    t_req                  r_req;
    logic                  hs_done;
    logic [TABLE_BITS-1:0] hs_slot;

    ast_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_accept),
        .i_key   (i_key),
        .o_done  (hs_done),
        .o_slot  (hs_slot)
    );

    assign o_busy = r_hashing;
    assign o_push = hs_done;

    always_comb begin
        o_req      = r_req;
        o_req.home = hs_slot;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_req.action <= i_action;
            r_req.key    <= i_key;
            r_req.site   <= (i_site >= SITE_W'(SITE_COUNT)) ? UNKNOWN_SITE : i_site;
            // untag falls back to the usable size when the hint is zero
            r_req.bytes  <= (i_action == ACT_UNTAG && i_byte_count == '0) ?
                            i_fallback_bytes : i_byte_count;
            r_req.home   <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hashing <= 1'b0;
        end else if (i_accept) begin
            r_hashing <= 1'b1;
        end else if (hs_done) begin
            r_hashing <= 1'b0;
        end
    end
endmodule

// ----- hdl/ast_engine.sv -----
// Table engine: probes, inserts, removes with backward shift, keeps per-site counters.
module ast_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_stats_enabled,
    input  logic                       i_table_present,
    input  logic                       i_q_valid,
    input  ast_pkg::t_req              i_q_head,
    output logic                       o_q_pop,
    output logic                       o_clearing,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [ast_pkg::SITE_W-1:0] o_site_out,
    output logic [ast_pkg::CNT_W-1:0]  o_alloc_count_out,
    output logic [ast_pkg::CNT_W-1:0]  o_alloc_bytes_out,
    output logic [ast_pkg::CNT_W-1:0]  o_free_count_out,
    output logic [ast_pkg::CNT_W-1:0]  o_free_bytes_out,
    output logic signed [63:0]         o_outstanding_total,
    output logic [ast_pkg::CNT_W-1:0]  o_drop_total
);
    import ast_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_DISP      = 4'd2;
    localparam logic [3:0] S_PROBE_RD  = 4'd3;
    localparam logic [3:0] S_PROBE_CHK = 4'd4;
    localparam logic [3:0] S_SCAN_RD   = 4'd5;
    localparam logic [3:0] S_SCAN_CHK  = 4'd6;
    localparam logic [3:0] S_SCAN_HASH = 4'd7;
    localparam logic [3:0] S_MOVE2     = 4'd8;
    localparam logic [3:0] S_UPDATE    = 4'd9;
    localparam logic [3:0] S_SUM       = 4'd10;
    localparam logic [3:0] S_OUT       = 4'd11;

    t_slot                 r_mem [SLOT_N];
    t_slot                 r_rd;
    logic [3:0]            r_state;
    t_req                  r_req;
    logic [SITE_W-1:0]     r_site;
    logic [2:0]            r_status;
    logic [TABLE_BITS-1:0] r_idx;
    logic [TABLE_BITS-1:0] r_hole;
    t_slot                 r_ent;
    logic [OCC_W-1:0]      r_occ;
    logic [CNT_W-1:0]      r_drop;
    logic [SITE_W-1:0]     r_sum;
    logic signed [63:0]    r_acc;
    logic [CNT_W-1:0]      r_ac [SITE_COUNT];
    logic [CNT_W-1:0]      r_ab [SITE_COUNT];
    logic [CNT_W-1:0]      r_fc [SITE_COUNT];
    logic [CNT_W-1:0]      r_fb [SITE_COUNT];

    logic                  mem_we;
    logic [TABLE_BITS-1:0] mem_wa;
    t_slot                 mem_wd;
    logic                  mem_re;
    logic                  hs_start;
    logic                  hs_done;
    logic [TABLE_BITS-1:0] hs_slot;
    logic [SITE_W-1:0]     c_sel;
    logic [TABLE_BITS-1:0] dh;
    logic [TABLE_BITS-1:0] dn;
    logic                  do_move;
    logic                  is_tag;
    logic                  tbl_full;
    logic signed [63:0]    diff;
    logic signed [64:0]    sum_w;

    ast_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hs_start),
        .i_key   (r_rd.key),
        .o_done  (hs_done),
        .o_slot  (hs_slot)
    );

    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign is_tag     = (r_req.action == ACT_TAG);
    assign tbl_full   = ({r_occ, 2'b00} >= (OCC_W+2)'(3 * SLOT_N));
    assign c_sel      = (r_state == S_SUM) ? r_sum : r_site;
    assign dh         = r_idx - r_hole;
    assign dn         = r_idx - hs_slot;
    assign do_move    = hs_done && (dn >= dh);
    assign diff       = $signed({1'b0, r_ac[c_sel]}) - $signed({1'b0, r_fc[c_sel]});
    assign sum_w      = {r_acc[63], r_acc} + {diff[63], diff};

    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_idx;
        mem_wd   = '0;
        mem_re   = 1'b0;
        hs_start = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_PROBE_RD, S_SCAN_RD: begin
                mem_re = 1'b1;
            end
            S_PROBE_CHK: begin
                if (is_tag && (r_rd.key == '0 || r_rd.key == r_req.key)) begin
                    mem_we = 1'b1;
                    mem_wd = '{key: r_req.key, site: r_site};
                end else if (!is_tag && r_rd.key == r_req.key) begin
                    mem_we = 1'b1;
                end
            end
            S_SCAN_CHK: begin
                hs_start = (r_rd.key != '0);
            end
            S_SCAN_HASH: begin
                if (do_move) begin
                    mem_we = 1'b1;
                    mem_wa = r_hole;
                    mem_wd = r_ent;
                end
            end
            S_MOVE2: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_occ   <= '0;
            r_drop  <= '0;
            r_sum   <= '0;
            r_acc   <= '0;
            o_valid <= 1'b0;
            for (int s = 0; s < SITE_COUNT; s++) begin
                r_ac[s] <= '0;
                r_ab[s] <= '0;
                r_fc[s] <= '0;
                r_fb[s] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            if (r_state != S_SUM) begin
                r_sum <= '0;
                r_acc <= '0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == TABLE_BITS'(SLOT_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req   <= i_q_head;
                        r_site  <= i_q_head.site;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (r_req.action[1]) begin
                        r_status <= ST_READ;
                        r_state  <= S_SUM;
                    end else if (!i_stats_enabled) begin
                        r_status <= ST_DISABLED;
                        r_state  <= S_SUM;
                    end else if (is_tag) begin
                        r_ac[r_site] <= sat_add(r_ac[r_site], CNT_W'(1));
                        r_ab[r_site] <= sat_add(r_ab[r_site], r_req.bytes);
                        r_idx        <= r_req.home;
                        if (r_req.key == '0 || !i_table_present) begin
                            r_status <= ST_DROPPED;
                            r_state  <= S_SUM;
                        end else if (tbl_full) begin
                            r_drop   <= sat_add(r_drop, CNT_W'(1));
                            r_status <= ST_DROPPED;
                            r_state  <= S_SUM;
                        end else begin
                            r_state <= S_PROBE_RD;
                        end
                    end else begin
                        r_idx <= r_req.home;
                        if (r_req.key == '0 || !i_table_present) begin
                            r_status <= ST_MISS;
                            r_site   <= UNKNOWN_SITE;
                            r_state  <= S_UPDATE;
                        end else begin
                            r_state <= S_PROBE_RD;
                        end
                    end
                end
                S_PROBE_RD: begin
                    r_state <= S_PROBE_CHK;
                end
                S_PROBE_CHK: begin
                    if (is_tag) begin
                        if (r_rd.key == '0) begin
                            r_occ    <= r_occ + 1'b1;
                            r_status <= ST_INSERTED;
                            r_state  <= S_SUM;
                        end else if (r_rd.key == r_req.key) begin
                            r_status <= ST_OVERWRITTEN;
                            r_state  <= S_SUM;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_PROBE_RD;
                        end
                    end else begin
                        if (r_rd.key == '0) begin
                            r_status <= ST_MISS;
                            r_site   <= UNKNOWN_SITE;
                            r_state  <= S_UPDATE;
                        end else if (r_rd.key == r_req.key) begin
                            if (r_rd.site >= SITE_W'(SITE_COUNT)) begin
                                r_status <= ST_MISS;
                                r_site   <= UNKNOWN_SITE;
                            end else begin
                                r_status <= ST_REMOVED;
                                r_site   <= r_rd.site;
                            end
                            if (r_occ != '0) begin
                                r_occ <= r_occ - 1'b1;
                            end
                            r_hole  <= r_idx;
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_PROBE_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    // an empty slot ends the cluster
                    if (r_rd.key == '0) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_ent   <= r_rd;
                        r_state <= S_SCAN_HASH;
                    end
                end
                S_SCAN_HASH: begin
                    if (hs_done) begin
                        if (do_move) begin
                            r_state <= S_MOVE2;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_MOVE2: begin
                    r_hole  <= r_idx;
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SCAN_RD;
                end
                S_UPDATE: begin
                    r_fc[r_site] <= sat_add(r_fc[r_site], CNT_W'(1));
                    r_fb[r_site] <= sat_add(r_fb[r_site], r_req.bytes);
                    r_state      <= S_SUM;
                end
                S_SUM: begin
                    // walk the known sites in order, saturating each addition
                    if (i_stats_enabled) begin
                        if (sum_w[64] != sum_w[63]) begin
                            r_acc <= sum_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                        end else begin
                            r_acc <= sum_w[63:0];
                        end
                    end
                    r_sum <= r_sum + 1'b1;
                    if (r_sum == SITE_W'(SITE_COUNT - 2)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid             <= 1'b1;
                    o_status            <= r_status;
                    o_site_out          <= r_site;
                    o_alloc_count_out   <= r_ac[c_sel];
                    o_alloc_bytes_out   <= r_ab[c_sel];
                    o_free_count_out    <= r_fc[c_sel];
                    o_free_bytes_out    <= r_fb[c_sel];
                    o_outstanding_total <= r_acc;
                    o_drop_total        <= r_drop;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- hdl/allocation_site_tracker_top.sv -----
// Allocation site tracker: hashing front, request queue, table engine.
// A request goes, as its kind needs, through key hashing, queue hand-off and dispatch,
// probing of slots, scanning of slots with a rehash of each key in compaction, moving of
// entries, charging of an untag, summation of the outstanding total and the output register.
// Throughput: one request at a time through the engine; the front takes the next while it runs.
// After reset the engine clears all 4096 table slots, one per cycle; busy stays high meanwhile.
// Each result shows on o_valid for one cycle; the receiver cannot stall.
module allocation_site_tracker_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_action,
    input  logic [63:0]                i_key,
    input  logic [ast_pkg::SITE_W-1:0] i_site,
    input  logic [ast_pkg::CNT_W-1:0]  i_byte_count,
    input  logic [ast_pkg::CNT_W-1:0]  i_fallback_bytes,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic                       i_cfg_data,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [ast_pkg::SITE_W-1:0] o_site_out,
    output logic [ast_pkg::CNT_W-1:0]  o_alloc_count_out,
    output logic [ast_pkg::CNT_W-1:0]  o_alloc_bytes_out,
    output logic [ast_pkg::CNT_W-1:0]  o_free_count_out,
    output logic [ast_pkg::CNT_W-1:0]  o_free_bytes_out,
    output logic signed [63:0]         o_outstanding_total,
    output logic [ast_pkg::CNT_W-1:0]  o_drop_total
);
    import ast_pkg::*;

    logic r_stats_enabled;
    logic r_table_present;
    logic accept;
    logic f_busy;
    logic f_push;
    t_req f_req;
    logic q_valid;
    logic q_full;
    t_req q_head;
    logic q_pop;
    logic clearing;

    assign busy   = f_busy | q_full | clearing;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats_enabled <= 1'b0;
            r_table_present <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STATS_ENABLED: r_stats_enabled <= i_cfg_data;
                CFG_TABLE_PRESENT: r_table_present <= i_cfg_data;
                default:           r_stats_enabled <= r_stats_enabled;
            endcase
        end
    end

    ast_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_action         (i_action),
        .i_key            (i_key),
        .i_site           (i_site),
        .i_byte_count     (i_byte_count),
        .i_fallback_bytes (i_fallback_bytes),
        .o_busy           (f_busy),
        .o_push           (f_push),
        .o_req            (f_req)
    );

    ast_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_req   (f_req),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    ast_engine u_engine (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_stats_enabled     (r_stats_enabled),
        .i_table_present     (r_table_present),
        .i_q_valid           (q_valid),
        .i_q_head            (q_head),
        .o_q_pop             (q_pop),
        .o_clearing          (clearing),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_site_out          (o_site_out),
        .o_alloc_count_out   (o_alloc_count_out),
        .o_alloc_bytes_out   (o_alloc_bytes_out),
        .o_free_count_out    (o_free_count_out),
        .o_free_bytes_out    (o_free_bytes_out),
        .o_outstanding_total (o_outstanding_total),
        .o_drop_total        (o_drop_total)
    );
endmodule

// ----- dv/tb_top.sv -----
// Testbench for the allocation site tracker: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps
module tb_top;
    import ast_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [CNT_W-1:0] MAX63 = {CNT_W{1'b1}};
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [2:0]        status;
        logic [SITE_W-1:0] site;
        logic [CNT_W-1:0]  a_cnt;
        logic [CNT_W-1:0]  a_bytes;
        logic [CNT_W-1:0]  f_cnt;
        logic [CNT_W-1:0]  f_bytes;
        logic [63:0]       outst;
        logic [CNT_W-1:0]  drops;
    } t_site_report;

    typedef struct {
        logic [1:0]        act;
        logic [63:0]       key;
        logic [SITE_W-1:0] site;
        logic [CNT_W-1:0]  bytes;
        logic [CNT_W-1:0]  fb;
        bit                has_st;
        logic [2:0]        st;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_action = '0;
    logic [63:0] i_key = '0;
    logic [SITE_W-1:0] i_site = '0;
    logic [CNT_W-1:0] i_byte_count = '0;
    logic [CNT_W-1:0] i_fallback_bytes = '0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic i_cfg_data = 1'b0;
    logic o_valid;
    logic [2:0] o_status;
    logic [SITE_W-1:0] o_site_out;
    logic [CNT_W-1:0] o_alloc_count_out, o_alloc_bytes_out, o_free_count_out, o_free_bytes_out;
    logic signed [63:0] o_outstanding_total;
    logic [CNT_W-1:0] o_drop_total;

    allocation_site_tracker_top dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the block
    bit                    m_stats_on;
    bit                    m_table_on;
    logic [63:0]           m_keys [SLOT_N];
    logic [SITE_W-1:0]     m_sites [SLOT_N];
    int                    m_occ;
    logic [CNT_W-1:0]      m_acnt [SITE_COUNT];
    logic [CNT_W-1:0]      m_abytes [SITE_COUNT];
    logic [CNT_W-1:0]      m_fcnt [SITE_COUNT];
    logic [CNT_W-1:0]      m_fbytes [SITE_COUNT];
    logic [CNT_W-1:0]      m_drops;

    t_site_report pending_reports[$];
    logic [63:0]  live_keys[$];
    int  errors = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;

    function automatic logic [CNT_W-1:0] add63(input logic [CNT_W-1:0] a, b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? MAX63 : s[CNT_W-1:0];
    endfunction

    function automatic logic [TABLE_BITS-1:0] slot_of(input logic [63:0] x);
        x = x ^ (x >> 33);
        x = x * MIX_MUL;
        x = x ^ (x >> 33);
        return x[TABLE_BITS-1:0];
    endfunction

    function automatic logic [2:0] table_put(input logic [63:0] k, input logic [SITE_W-1:0] s);
        logic [TABLE_BITS-1:0] p;
        if (k == 0 || !m_table_on) return ST_DROPPED;
        if (m_occ * 4 >= SLOT_N * 3) begin
            m_drops = add63(m_drops, CNT_W'(1));
            return ST_DROPPED;
        end
        p = slot_of(k);
        for (int i = 0; i < SLOT_N; i++) begin
            if (m_keys[p] == 0) begin
                m_keys[p] = k;
                m_sites[p] = s;
                m_occ++;
                return ST_INSERTED;
            end
            if (m_keys[p] == k) begin
                m_sites[p] = s;
                return ST_OVERWRITTEN;
            end
            p++;
        end
        m_drops = add63(m_drops, CNT_W'(1));
        return ST_DROPPED;
    endfunction

    function automatic bit table_take(input logic [63:0] k, output logic [SITE_W-1:0] s);
        logic [TABLE_BITS-1:0] p, hole, idx, nat, dh, dn;
        s = UNKNOWN_SITE;
        if (k == 0 || !m_table_on) return 1'b0;
        p = slot_of(k);
        for (int i = 0; i < SLOT_N; i++) begin
            if (m_keys[p] == 0) return 1'b0;
            if (m_keys[p] == k) begin
                s = m_sites[p];
                m_keys[p] = 0;
                if (m_occ > 0) m_occ--;
                hole = p;
                idx = p + 1'b1;
                // shift later cluster members back over the hole
                for (int n = 1; n < SLOT_N; n++) begin
                    if (m_keys[idx] == 0) break;
                    nat = slot_of(m_keys[idx]);
                    dh = idx - hole;
                    dn = idx - nat;
                    if (dn >= dh) begin
                        m_keys[hole] = m_keys[idx];
                        m_sites[hole] = m_sites[idx];
                        m_keys[idx] = 0;
                        hole = idx;
                    end
                    idx++;
                end
                return 1'b1;
            end
            p++;
        end
        return 1'b0;
    endfunction

    function automatic logic [63:0] outstanding_sum();
        logic signed [64:0] acc, d;
        acc = 0;
        if (!m_stats_on) return 64'd0;
        for (int s = 0; s < SITE_COUNT; s++) begin
            if (s == UNKNOWN_SITE) continue;
            d = $signed({2'b0, m_acnt[s]}) - $signed({2'b0, m_fcnt[s]});
            acc = acc + d;
            if (acc > 65'sh0_7fff_ffff_ffff_ffff) acc = 65'sh0_7fff_ffff_ffff_ffff;
            if (acc < -65'sh0_8000_0000_0000_0000) acc = -65'sh0_8000_0000_0000_0000;
        end
        return acc[63:0];
    endfunction

    function automatic t_site_report track_request(input t_row r);
        t_site_report e;
        logic [SITE_W-1:0] s, found;
        s = (r.site >= SITE_COUNT) ? UNKNOWN_SITE : r.site;
        if (r.act >= ACT_READ) e.status = ST_READ;
        else if (!m_stats_on) e.status = ST_DISABLED;
        else if (r.act == ACT_TAG) begin
            m_acnt[s] = add63(m_acnt[s], CNT_W'(1));
            m_abytes[s] = add63(m_abytes[s], r.bytes);
            e.status = table_put(r.key, s);
        end else begin
            if (table_take(r.key, found) && found < SITE_COUNT) begin
                e.status = ST_REMOVED;
                s = found;
            end else begin
                e.status = ST_MISS;
                s = UNKNOWN_SITE;
            end
            m_fcnt[s] = add63(m_fcnt[s], CNT_W'(1));
            m_fbytes[s] = add63(m_fbytes[s], r.bytes != 0 ? r.bytes : r.fb);
        end
        e.site = s;
        e.a_cnt = m_acnt[s];
        e.a_bytes = m_abytes[s];
        e.f_cnt = m_fcnt[s];
        e.f_bytes = m_fbytes[s];
        e.outst = outstanding_sum();
        e.drops = m_drops;
        return e;
    endfunction

    task automatic send_request(input t_row r);
        bit done;
        t_site_report e;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 99) < 29) begin
                start = 1'b0;
            end else begin
                i_action = r.act;
                i_key = r.key;
                i_site = r.site;
                i_byte_count = r.bytes;
                i_fallback_bytes = r.fb;
                start = 1'b1;
            end
            @(posedge i_clk);
            if (start && !busy) begin
                done = 1'b1;
                e = track_request(r);
                if (r.has_st && e.status != r.st) begin
                    $error("status: expected %0d, actual model %0d", r.st, e.status);
                    errors++;
                end
                pending_reports.push_back(e);
                if (r.act == ACT_TAG && r.key != 0) live_keys.push_back(r.key);
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic val);
        // drain, then let the engine settle before touching registers
        @(negedge i_clk);
        start = 1'b0;
        while (pending_reports.size() != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_STATS_ENABLED) m_stats_on = val;
        else m_table_on = val;
    endtask

    function automatic t_row random_row();
        t_row r;
        int pick, j;
        pick = $urandom_range(0, 99);
        r.act = pick < 40 ? ACT_TAG : pick < 80 ? ACT_UNTAG : pick < 95 ? ACT_READ : ACT_SPARE;
        r.key = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 5) r.key = 0;
        else if (live_keys.size() != 0 && ((r.act == ACT_UNTAG && pick < 80) || pick < 15)) begin
            j = $urandom_range(0, live_keys.size() - 1);
            r.key = live_keys[j];
            if (r.act == ACT_UNTAG) live_keys.delete(j);
        end
        r.site = $urandom_range(0, 9) == 0 ? SITE_W'($urandom_range(0, 31)) :
                 SITE_W'($urandom_range(0, 18));
        r.bytes = $urandom_range(0, 3) == 0 ? CNT_W'({$urandom, $urandom}) :
                  CNT_W'($urandom_range(0, 5000));
        if ($urandom_range(0, 3) == 0) r.bytes = 0;
        r.fb = $urandom_range(0, 1) ? CNT_W'({$urandom, $urandom}) :
               CNT_W'($urandom_range(0, 5000));
        r.has_st = 1'b0;
        r.st = '0;
        return r;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= 100 && i < 200);
            send_request(random_row());
        end
        no_idle = 1'b0;
    endtask

    t_row stats_off_rows[] = '{
        '{ACT_TAG,   64'h1, 5'd0, 63'd10, 63'd0, 1'b1, ST_DISABLED},
        '{ACT_UNTAG, 64'h1, 5'd0, 63'd0,  63'd7, 1'b1, ST_DISABLED},
        '{ACT_READ,  64'h0, 5'd0, 63'd0,  63'd0, 1'b1, ST_READ}
    };

    t_row stats_on_rows[] = '{
        '{ACT_TAG,   64'hffff_ffff_ffff_ffff, 5'd0,  MAX63,  63'd0, 1'b1, ST_INSERTED},
        '{ACT_TAG,   64'hffff_ffff_ffff_ffff, 5'd5,  MAX63,  63'd0, 1'b1, ST_OVERWRITTEN},
        '{ACT_TAG,   64'h0,                   5'd3,  63'd9,  63'd0, 1'b1, ST_DROPPED},
        '{ACT_UNTAG, 64'hffff_ffff_ffff_ffff, 5'd0,  63'd0,  MAX63, 1'b1, ST_REMOVED},
        '{ACT_UNTAG, 64'hffff_ffff_ffff_ffff, 5'd0,  63'd4,  63'd0, 1'b1, ST_MISS},
        '{ACT_UNTAG, 64'h0,                   5'd0,  63'd0,  63'd1, 1'b1, ST_MISS},
        '{ACT_TAG,   64'h2,                   5'd31, MAX63,  63'd0, 1'b1, ST_INSERTED},
        '{ACT_TAG,   64'h3,                   5'd18, MAX63,  63'd0, 1'b1, ST_INSERTED},
        '{ACT_SPARE, 64'h0,                   5'd31, 63'd0,  63'd0, 1'b1, ST_READ},
        '{ACT_READ,  64'h0,                   5'd5,  63'd0,  63'd0, 1'b1, ST_READ},
        '{ACT_TAG,   64'h8000_0000_0000_0000, 5'd1,  63'd1,  63'd0, 1'b1, ST_INSERTED},
        '{ACT_UNTAG, 64'h2,                   5'd0,  MAX63,  MAX63, 1'b1, ST_REMOVED},
        '{ACT_UNTAG, 64'h8000_0000_0000_0000, 5'd9,  63'd0,  63'd0, 1'b1, ST_REMOVED},
        '{ACT_UNTAG, 64'h1234,                5'd0,  63'd0,  63'd0, 1'b1, ST_MISS}
    };

    t_row no_table_rows[] = '{
        '{ACT_TAG,   64'h5, 5'd2, 63'd3, 63'd0, 1'b1, ST_DROPPED},
        '{ACT_UNTAG, 64'h3, 5'd0, 63'd0, 63'd8, 1'b1, ST_MISS},
        '{ACT_READ,  64'h0, 5'd2, 63'd0, 63'd0, 1'b1, ST_READ}
    };

    task automatic run_rows(input t_row rows[]);
        foreach (rows[i]) send_request(rows[i]);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_site_report e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result, status %0d", o_status);
                errors++;
            end else begin
                e = pending_reports.pop_front();
                check_field("status", e.status, o_status);
                check_field("site_out", e.site, o_site_out);
                check_field("alloc_count_out", e.a_cnt, o_alloc_count_out);
                check_field("alloc_bytes_out", e.a_bytes, o_alloc_bytes_out);
                check_field("free_count_out", e.f_cnt, o_free_count_out);
                check_field("free_bytes_out", e.f_bytes, o_free_bytes_out);
                check_field("outstanding_total", e.outst, o_outstanding_total);
                check_field("drop_total", e.drops, o_drop_total);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_row r;
        m_stats_on = 1'b0;
        m_table_on = 1'b1;
        m_occ = 0;
        m_drops = '0;
        foreach (m_keys[i]) begin
            m_keys[i] = '0;
            m_sites[i] = '0;
        end
        foreach (m_acnt[i]) begin
            m_acnt[i] = '0;
            m_abytes[i] = '0;
            m_fcnt[i] = '0;
            m_fbytes[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_rows(stats_off_rows);
        write_reg(CFG_TABLE_PRESENT, 1'b1);
        write_reg(CFG_STATS_ENABLED, 1'b1);
        run_rows(stats_on_rows);
        write_reg(CFG_TABLE_PRESENT, 1'b0);
        run_rows(no_table_rows);
        random_phase(60);
        write_reg(CFG_TABLE_PRESENT, 1'b1);
        random_phase(500);

        // burst of tags to grow the clusters, then mixed churn
        for (int i = 0; i < 20; i++) begin
            r = random_row();
            r.act = ACT_TAG;
            send_request(r);
        end
        random_phase(450);

        write_reg(CFG_STATS_ENABLED, 1'b0);
        write_reg(CFG_TABLE_PRESENT, 1'b0);
        random_phase(60);
        write_reg(CFG_STATS_ENABLED, 1'b1);
        random_phase(60);

        @(negedge i_clk);
        start = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/ast_pkg.sv
hdl/ast_hash.sv
hdl/ast_queue.sv
hdl/ast_front.sv
hdl/ast_engine.sv
hdl/allocation_site_tracker_top.sv
dv/tb_top.sv
